// ===== rtl/slrm_pkg.sv =====
// ----------------------------------------------------------------------------
// slrm_pkg
// Shared types and constants for the sequence loss and reorder monitor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package slrm_pkg;

  // field widths
  localparam int unsigned CMD_W = 2;
  localparam int unsigned ID_W  = 16;
  localparam int unsigned CNT_W = 13;
  localparam int unsigned DIS_W = 16;
  localparam int unsigned CUR_W = CNT_W + 1;

  // command codes
  localparam logic [CMD_W-1:0] CMD_RECORD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FETCH  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NOP    = 2'd3;

  // controller to datapath commands
  typedef struct packed {
    logic rec;      // record transaction accepted
    logic clr;      // clear transaction accepted
    logic nop;      // other transaction accepted, report counters
    logic sweep;    // zero one bitmap entry
    logic rd;       // read bitmap at scan cursor, advance cursor
    logic ev_hit;   // scanned entry was seen, end current run
    logic ev_miss;  // scanned entry was missing, report it
    logic fin;      // scan passed the expected count, report done
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;     // output register empty or being taken
    logic sweep_last;   // clearing pass at last entry
    logic cursor_past;  // scan cursor above expected count
    logic entry_seen;   // registered bitmap read data
  } dp_status_t;

endpackage

// ===== rtl/slrm_ctrl.sv =====
// ----------------------------------------------------------------------------
// slrm_ctrl
// Controller: accepts transactions, sequences the clearing pass and the scan.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module slrm_ctrl
  import slrm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [CMD_W-1:0] cmd_i,
  input  dp_status_t       status_i,
  output dp_cmd_t          cmd_o
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD,
    ST_EV
  } state_e;

  state_e state_q, state_d;
  logic   take;

  // input handshake
  assign in_stall_o = !((state_q == ST_IDLE) && status_i.out_free);
  assign take       = in_valid_i && !in_stall_o;

  // command decode and next state
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.sweep = 1'b1;
        if (status_i.sweep_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (take) begin
          case (cmd_i)
            CMD_RECORD: cmd_o.rec = 1'b1;
            CMD_FETCH:  state_d = ST_RD;
            CMD_CLEAR: begin
              cmd_o.clr = 1'b1;
              state_d   = ST_CLEAR;
            end
            default:    cmd_o.nop = 1'b1;
          endcase
        end
      end
      ST_RD: begin
        if (status_i.cursor_past) begin
          cmd_o.fin = 1'b1;
          state_d   = ST_IDLE;
        end else begin
          cmd_o.rd = 1'b1;
          state_d  = ST_EV;
        end
      end
      ST_EV: begin
        if (status_i.entry_seen) begin
          cmd_o.ev_hit = 1'b1;
          state_d      = ST_RD;
        end else begin
          cmd_o.ev_miss = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state register, clearing pass runs after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/slrm_datapath.sv =====
// ----------------------------------------------------------------------------
// slrm_datapath
// Seen bitmap, session counters, expected count register and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module slrm_datapath
  import slrm_pkg::*;
#(
  parameter int unsigned MAX_PACKETS = 4096
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i,
  input  logic [ID_W-1:0]  packet_id_i,
  input  dp_cmd_t          cmd_i,
  output dp_status_t       status_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [CNT_W-1:0] missing_id_o,
  output logic             found_o,
  output logic             done_res_o,
  output logic             out_of_range_o,
  output logic [CNT_W-1:0] lost_count_o,
  output logic [CNT_W-1:0] longest_run_o,
  output logic [DIS_W-1:0] disorder_count_o
);

  // identifiers above the 13-bit register range can never be reached
  localparam int unsigned CNT_MAX = (1 << CNT_W) - 1;
  localparam int unsigned TOP_ID  = (MAX_PACKETS < CNT_MAX) ? MAX_PACKETS : CNT_MAX;
  localparam int unsigned DEPTH   = TOP_ID + 1;
  localparam int unsigned AW      = $clog2(DEPTH);
  localparam logic [CNT_W-1:0] LIMIT_CAP = CNT_W'(TOP_ID);
  localparam logic [CNT_W-1:0] CNT_SAT   = {CNT_W{1'b1}};
  localparam logic [DIS_W-1:0] DIS_SAT   = {DIS_W{1'b1}};

  logic             seen_mem [DEPTH];
  logic             rd_data_q;
  logic [CNT_W-1:0] rd_idx_q;

  logic [CNT_W-1:0] exp_q;
  logic [AW-1:0]    sweep_q, sweep_d;
  logic [CUR_W-1:0] cursor_q, cursor_d;
  logic [CNT_W-1:0] lost_q, lost_d;
  logic [CNT_W-1:0] run_q, run_d;
  logic [CNT_W-1:0] best_q, best_d;
  logic [ID_W-1:0]  prev_q, prev_d;
  logic             have_q, have_d;
  logic [DIS_W-1:0] dis_q, dis_d;
  logic             out_valid_q, out_valid_d;

  logic [CNT_W-1:0] limit;
  logic             id_ok;
  logic             emit;

  // effective expected count
  assign limit = (exp_q > LIMIT_CAP) ? LIMIT_CAP : exp_q;
  assign id_ok = (packet_id_i != '0) && (packet_id_i <= ID_W'(limit));
  assign emit  = cmd_i.rec | cmd_i.clr | cmd_i.nop | cmd_i.fin | cmd_i.ev_miss;

  // status to controller
  assign status_o.out_free    = !out_valid_q || !out_stall_i;
  assign status_o.sweep_last  = (sweep_q == AW'(DEPTH - 1));
  assign status_o.cursor_past = (cursor_q > CUR_W'(limit));
  assign status_o.entry_seen  = rd_data_q;

  // session state update
  always_comb begin
    sweep_d  = sweep_q;
    cursor_d = cursor_q;
    lost_d   = lost_q;
    run_d    = run_q;
    best_d   = best_q;
    prev_d   = prev_q;
    have_d   = have_q;
    dis_d    = dis_q;
    if (cmd_i.clr) begin
      sweep_d  = '0;
      cursor_d = CUR_W'(1);
      lost_d   = '0;
      run_d    = '0;
      best_d   = '0;
      prev_d   = '0;
      have_d   = 1'b0;
      dis_d    = '0;
    end
    if (cmd_i.rec && id_ok) begin
      if (have_q && (packet_id_i < prev_q) && (dis_q != DIS_SAT)) begin
        dis_d = dis_q + DIS_W'(1);
      end
      prev_d = packet_id_i;
      have_d = 1'b1;
    end
    if (cmd_i.sweep) begin
      sweep_d = sweep_q + AW'(1);
    end
    if (cmd_i.rd) begin
      cursor_d = cursor_q + CUR_W'(1);
    end
    if (cmd_i.ev_hit) begin
      run_d = '0;
    end
    if (cmd_i.ev_miss) begin
      if (lost_q != CNT_SAT) begin
        lost_d = lost_q + CNT_W'(1);
      end
      if (run_q != CNT_SAT) begin
        run_d = run_q + CNT_W'(1);
      end
      if (run_d > best_q) begin
        best_d = run_d;
      end
    end
  end

  // output register handshake
  assign out_valid_d = emit || (out_valid_q && out_stall_i);

  // control and session registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q       <= '0;
      sweep_q     <= '0;
      cursor_q    <= CUR_W'(1);
      lost_q      <= '0;
      run_q       <= '0;
      best_q      <= '0;
      prev_q      <= '0;
      have_q      <= 1'b0;
      dis_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        exp_q <= cfg_wdata_i;
      end
      sweep_q     <= sweep_d;
      cursor_q    <= cursor_d;
      lost_q      <= lost_d;
      run_q       <= run_d;
      best_q      <= best_d;
      prev_q      <= prev_d;
      have_q      <= have_d;
      dis_q       <= dis_d;
      out_valid_q <= out_valid_d;
    end
  end

  // seen bitmap, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.sweep) begin
      seen_mem[sweep_q] <= 1'b0;
    end else if (cmd_i.rec && id_ok) begin
      seen_mem[packet_id_i[AW-1:0]] <= 1'b1;
    end
    if (cmd_i.rd) begin
      rd_data_q <= seen_mem[cursor_q[AW-1:0]];
      rd_idx_q  <= cursor_q[CNT_W-1:0];
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (emit) begin
      missing_id_o     <= cmd_i.ev_miss ? rd_idx_q : '0;
      found_o          <= cmd_i.ev_miss;
      done_res_o       <= cmd_i.fin;
      out_of_range_o   <= cmd_i.rec && !id_ok;
      lost_count_o     <= lost_d;
      longest_run_o    <= best_d;
      disorder_count_o <= dis_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/sequence_loss_reorder_monitor.sv =====
// ----------------------------------------------------------------------------
// sequence_loss_reorder_monitor
// Tracks received packet sequence numbers, counts reordering and finds loss.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries cmd_i and packet_id_i;
//   output channel (out_valid_o / out_stall_i) carries one result per input
//   transaction. expected_count is written through cfg_we_i / cfg_wdata_i,
//   by the user only while the block is idle; the block does not enforce it.
//   Record, clear and no-op transactions load their result into the output
//   register at the accepting edge; records sustain one per cycle while the
//   output side keeps up.
//   A fetch holds the input stalled until it answers; each bitmap entry it
//   examines takes a registered bitmap read, then an evaluation. The result
//   is loaded with the evaluation of the first missing entry, or in the cycle
//   after the last examination once the cursor is past the expected count.
//   Reset and every clear command start a clearing pass over the bitmap's
//   min(MAX_PACKETS, 8191) + 1 entries, during which no transaction is taken;
//   configuration writes are taken as ever.
//   A new transaction is taken only while the controller is idle and the
//   output register is empty or being taken in the same cycle; a stalled
//   result holds in the output register and blocks further input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sequence_loss_reorder_monitor
  import slrm_pkg::*;
#(
  parameter int unsigned MAX_PACKETS = 4096
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [CMD_W-1:0] cmd_i,
  input  logic [ID_W-1:0]  packet_id_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [CNT_W-1:0] missing_id_o,
  output logic             found_o,
  output logic             done_res_o,
  output logic             out_of_range_o,
  output logic [CNT_W-1:0] lost_count_o,
  output logic [CNT_W-1:0] longest_run_o,
  output logic [DIS_W-1:0] disorder_count_o
);

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  // controller
  slrm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_i      (cmd_i),
    .status_i   (dp_status),
    .cmd_o      (dp_cmd)
  );

  // datapath
  slrm_datapath #(
    .MAX_PACKETS (MAX_PACKETS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .packet_id_i      (packet_id_i),
    .cmd_i            (dp_cmd),
    .status_o         (dp_status),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .missing_id_o     (missing_id_o),
    .found_o          (found_o),
    .done_res_o       (done_res_o),
    .out_of_range_o   (out_of_range_o),
    .lost_count_o     (lost_count_o),
    .longest_run_o    (longest_run_o),
    .disorder_count_o (disorder_count_o)
  );

endmodule
